@@ sv/scrgb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrgb_pkg - shared types, constants and arithmetic for the colormap block
// Q16 unit format (65536 = 1.0), map codes, ramp and divide-by-constant helpers.
// ----------------------------------------------------------------------------
package scrgb_pkg;

  localparam int IN_FRAC_BITS = 16;
  localparam int OUT_BITS     = 8;
  localparam int LEVEL_W      = IN_FRAC_BITS + 1;
  localparam int Q_FRAC       = 16;
  localparam int Q_W          = Q_FRAC + 1;
  localparam int SW           = 22;
  localparam int MAP_W        = 3;

  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [Q_W-1:0]       q_t;
  typedef logic signed [SW-1:0] s_t;
  typedef logic [OUT_BITS-1:0]  pix_t;

  typedef enum logic [MAP_W-1:0] {
    MAP_JET    = 3'd0,
    MAP_HOT    = 3'd1,
    MAP_GRAY   = 3'd2,
    MAP_HSV    = 3'd3,
    MAP_BONE   = 3'd4,
    MAP_COPPER = 3'd5,
    MAP_WHEEL  = 3'd6,
    MAP_WAVE   = 3'd7
  } map_sel_t;

  typedef struct packed {
    q_t red;
    q_t green;
    q_t blue;
  } rgb_q_t;

  localparam level_t LEVEL_ONE = level_t'(1) << IN_FRAC_BITS;

  localparam q_t Q_ONE            = q_t'(65536);
  localparam q_t Q_HALF           = q_t'(32768);
  localparam q_t Q_QUARTER        = q_t'(16384);
  localparam q_t Q_THREE_QUARTERS = q_t'(49152);
  localparam q_t Q_THREE_EIGHTHS  = q_t'(24576);
  localparam q_t Q_THIRD          = q_t'(21845);
  localparam q_t Q_TWO_THIRDS     = q_t'(43691);
  localparam q_t BONE_GRAY        = q_t'(57016);
  localparam q_t BONE_TINT        = q_t'(8520);
  localparam q_t COPPER_RED       = q_t'(85197);
  localparam q_t WAVE_SLOPE       = q_t'(39322);
  localparam q_t WAVE_BASE        = q_t'(19661);
  localparam q_t WAVE_KNEE        = q_t'(52429);
  localparam q_t WAVE_DIP         = q_t'(13107);

  localparam s_t NARROW_PEAK = s_t'(98304);
  localparam s_t WIDE_PEAK   = s_t'(131072);

  // Reciprocals: floor(m * RECIP >> SHIFT) is exact for m < 2**17.
  localparam logic [15:0] RECIP3 = 16'd43691;
  localparam logic [17:0] RECIP9 = 18'd233017;

  function automatic s_t to_s(input q_t v);
    return s_t'({{(SW-Q_W){1'b0}}, v});
  endfunction

  function automatic q_t sat_unit(input s_t v);
    if (v < 0) begin
      return '0;
    end else if (v > to_s(Q_ONE)) begin
      return Q_ONE;
    end
    return v[Q_W-1:0];
  endfunction

  function automatic s_t abs_s(input s_t v);
    return (v < 0) ? -v : v;
  endfunction

  // 1 inside 1/8, 0 beyond 3/8
  function automatic q_t ramp_narrow(input s_t d);
    s_t a;
    a = abs_s(d);
    return sat_unit(NARROW_PEAK - (a <<< 2));
  endfunction

  // 1 inside 1/6, 0 beyond 1/3
  function automatic q_t ramp_wide(input s_t d);
    s_t a;
    a = abs_s(d);
    return sat_unit(WIDE_PEAK - (a <<< 2) - (a <<< 1));
  endfunction

  function automatic logic [15:0] div3(input logic [16:0] m);
    logic [33:0] p;
    p = {17'd0, m} * {18'd0, RECIP3};
    return p[32:17];
  endfunction

  function automatic logic [13:0] div9(input logic [16:0] m);
    logic [34:0] p;
    p = {18'd0, m} * {17'd0, RECIP9};
    return p[34:21];
  endfunction

  // round(n * 8/3), saturated to one; n * 8/3 + 1/3 = 2n + (2n + 1)/3
  function automatic q_t hot_lin(input s_t n);
    logic [14:0] nn;
    logic [16:0] m;
    if (n <= 0) begin
      return '0;
    end else if (n >= to_s(Q_THREE_EIGHTHS)) begin
      return Q_ONE;
    end
    nn = n[14:0];
    m  = {1'b0, nn, 1'b1};
    return q_t'({nn, 1'b0}) + q_t'(div3(m));
  endfunction

  function automatic rgb_q_t jet(input q_t x);
    rgb_q_t c;
    s_t     xs;
    xs      = to_s(x);
    c.red   = ramp_narrow(xs - to_s(Q_THREE_QUARTERS));
    c.green = ramp_narrow(xs - to_s(Q_HALF));
    c.blue  = ramp_narrow(xs - to_s(Q_QUARTER));
    return c;
  endfunction

  function automatic rgb_q_t hot(input q_t x);
    rgb_q_t c;
    s_t     xs;
    xs      = to_s(x);
    c.red   = hot_lin(xs);
    c.green = hot_lin(xs - to_s(Q_THREE_EIGHTHS));
    c.blue  = sat_unit((xs - to_s(Q_THREE_QUARTERS)) <<< 2);
    return c;
  endfunction

  // clamp to one, then rescale from the input fraction width to Q16
  function automatic q_t level_to_q(input level_t lv);
    level_t                    lc;
    logic [LEVEL_W+Q_FRAC-1:0] w;
    lc = (lv > LEVEL_ONE) ? LEVEL_ONE : lv;
    w  = {lc, {Q_FRAC{1'b0}}} >> IN_FRAC_BITS;
    return w[Q_W-1:0];
  endfunction

  // scale Q16 to the output range, half up
  function automatic pix_t quant(input q_t v);
    logic [Q_W+OUT_BITS-1:0] p;
    p = {v, {OUT_BITS{1'b0}}} - (Q_W + OUT_BITS)'(v) + (Q_W + OUT_BITS)'(Q_HALF);
    return p[Q_FRAC+OUT_BITS-1:Q_FRAC];
  endfunction

endpackage

@@ sv/scrgb_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrgb_in_if - level input channel
// Valid/ready channel carrying one scalar level per transaction.
// ----------------------------------------------------------------------------
interface scrgb_in_if;
  logic                  valid;
  logic                  ready;
  scrgb_pkg::level_t     level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

@@ sv/scrgb_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrgb_out_if - color output channel
// Valid/ready channel carrying one red/green/blue pixel per transaction.
// ----------------------------------------------------------------------------
interface scrgb_out_if;
  logic                valid;
  logic                ready;
  scrgb_pkg::pix_t     red;
  scrgb_pkg::pix_t     green;
  scrgb_pkg::pix_t     blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ sv/scrgb_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrgb_cfg_if - configuration write channel
// Valid/ready channel carrying the map selection on each write transaction.
// ----------------------------------------------------------------------------
interface scrgb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scrgb_pkg::MAP_W-1:0]   map_select;

  modport source (output valid, output map_select, input ready);
  modport sink   (input valid, input map_select, output ready);
endinterface

@@ sv/scalar_to_rgb_colormap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap - false-color mapper from scalar level to RGB pixel
// Clamps a level to [0, 1] and maps it through one of eight colormaps.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one level per transaction (Q16, 65536 = 1.0, larger values clamp).
//   out_chan : one red/green/blue pixel per accepted level, in input order.
//   cfg_chan : writes map_select (0 jet, 1 hot, 2 gray, 3 hsv, 4 bone,
//              5 copper, 6 wheel, 7 wave); always ready. Write it only while
//              no pixel is in flight.
// Timing: an accepted level lands in the input register; map and scaling run
//   between it and the output register, which drives out_chan.valid and the
//   pixel. Throughput is one pixel per cycle while out_chan.ready stays high,
//   set by the single register-to-register pass of the map logic.
// Reset (rst_n low, synchronous): both stages empty, map_select = jet.
// Backpressure: while out_chan.ready is low the output register holds its
//   pixel; one more level is still taken into the input register, after
//   which in_chan.ready drops until the output moves.
// ----------------------------------------------------------------------------
module scalar_to_rgb_colormap (
  input  logic               clk,
  input  logic               rst_n,
  scrgb_in_if.sink           in_chan,
  scrgb_out_if.source        out_chan,
  scrgb_cfg_if.sink          cfg_chan
);

  scrgb_pkg::map_sel_t map_sel_r;
  scrgb_pkg::map_sel_t map_sel_nxt;

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  scrgb_pkg::level_t   s1_level_r;

  logic                out_valid_r;
  logic                out_valid_nxt;
  scrgb_pkg::pix_t     red_r;
  scrgb_pkg::pix_t     green_r;
  scrgb_pkg::pix_t     blue_r;

  logic                out_free;
  logic                in_take;
  logic                s1_move;

  scrgb_pkg::q_t       x;
  scrgb_pkg::rgb_q_t   rgb_q;
  scrgb_pkg::pix_t     red_c;
  scrgb_pkg::pix_t     green_c;
  scrgb_pkg::pix_t     blue_c;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_take  = in_chan.valid && in_chan.ready;

  assign in_chan.ready  = !s1_valid_r || out_free;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid = out_valid_r;
  assign out_chan.red   = red_r;
  assign out_chan.green = green_r;
  assign out_chan.blue  = blue_r;

  assign x = scrgb_pkg::level_to_q(s1_level_r);

  scrgb_map u_map (
    .x   (x),
    .sel (map_sel_r),
    .rgb (rgb_q)
  );

  scrgb_quant u_quant (
    .rgb   (rgb_q),
    .red   (red_c),
    .green (green_c),
    .blue  (blue_c)
  );

  always_comb begin
    map_sel_nxt = map_sel_r;
    if (cfg_chan.valid) begin
      map_sel_nxt = scrgb_pkg::map_sel_t'(cfg_chan.map_select);
    end

    // advance the input stage whenever it can hand off or is empty
    s1_valid_nxt = s1_valid_r;
    if (in_chan.ready) begin
      s1_valid_nxt = in_chan.valid;
    end

    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_sel_r   <= scrgb_pkg::MAP_JET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      map_sel_r   <= map_sel_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_chan.level;
    end
    // hold the pixel while the receiver stalls
    if (s1_move) begin
      red_r   <= red_c;
      green_r <= green_c;
      blue_r  <= blue_c;
    end
  end

endmodule

@@ sv/scrgb_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrgb_map - piecewise-linear colormap evaluation
// Maps a Q16 level in [0, 1] to Q16 red, green and blue for the selected map.
// ----------------------------------------------------------------------------
module scrgb_map (
  input  scrgb_pkg::q_t       x,
  input  scrgb_pkg::map_sel_t sel,
  output scrgb_pkg::rgb_q_t   rgb
);

  function automatic scrgb_pkg::rgb_q_t hsv(input scrgb_pkg::q_t v);
    scrgb_pkg::rgb_q_t c;
    scrgb_pkg::s_t     vs;
    vs      = scrgb_pkg::to_s(v);
    c.red   = scrgb_pkg::sat_unit(
                scrgb_pkg::to_s(scrgb_pkg::ramp_wide(vs)) +
                scrgb_pkg::to_s(scrgb_pkg::ramp_wide(scrgb_pkg::to_s(scrgb_pkg::Q_ONE) - vs)));
    c.green = scrgb_pkg::ramp_wide(vs - scrgb_pkg::to_s(scrgb_pkg::Q_THIRD));
    c.blue  = scrgb_pkg::ramp_wide(vs - scrgb_pkg::to_s(scrgb_pkg::Q_TWO_THIRDS));
    return c;
  endfunction

  function automatic scrgb_pkg::q_t bone_ch(input scrgb_pkg::q_t v, input scrgb_pkg::q_t h);
    logic [33:0] p;
    p = 34'(v) * 34'(scrgb_pkg::BONE_GRAY) + 34'(h) * 34'(scrgb_pkg::BONE_TINT) +
        34'(scrgb_pkg::Q_HALF);
    return scrgb_pkg::sat_unit(scrgb_pkg::s_t'({{(scrgb_pkg::SW-18){1'b0}}, p[33:16]}));
  endfunction

  function automatic scrgb_pkg::rgb_q_t bone(input scrgb_pkg::q_t v);
    scrgb_pkg::rgb_q_t c;
    scrgb_pkg::rgb_q_t h;
    h       = scrgb_pkg::hot(v);
    c.red   = bone_ch(v, h.blue);
    c.green = bone_ch(v, h.green);
    c.blue  = bone_ch(v, h.red);
    return c;
  endfunction

  function automatic scrgb_pkg::rgb_q_t copper(input scrgb_pkg::q_t v);
    scrgb_pkg::rgb_q_t c;
    logic [34:0]       p;
    logic [17:0]       t3;
    logic [17:0]       t1;
    p       = 35'(v) * 35'(scrgb_pkg::COPPER_RED) + 35'(scrgb_pkg::Q_HALF);
    c.red   = scrgb_pkg::sat_unit(scrgb_pkg::s_t'({{(scrgb_pkg::SW-19){1'b0}}, p[34:16]}));
    // round(3v/4) = (3v + 2) >> 2, round(v/2) = (v + 1) >> 1
    t3      = (18'(v) << 1) + 18'(v) + 18'd2;
    c.green = scrgb_pkg::q_t'(t3[17:2]);
    t1      = 18'(v) + 18'd1;
    c.blue  = scrgb_pkg::q_t'(t1[17:1]);
    return c;
  endfunction

  function automatic scrgb_pkg::rgb_q_t wave(input scrgb_pkg::q_t v);
    scrgb_pkg::rgb_q_t c;
    scrgb_pkg::s_t     vs;
    scrgb_pkg::s_t     t0;
    scrgb_pkg::s_t     n0;
    scrgb_pkg::s_t     up;
    scrgb_pkg::s_t     tg;
    scrgb_pkg::s_t     add;
    scrgb_pkg::s_t     tb;
    scrgb_pkg::s_t     nb;
    scrgb_pkg::s_t     sub;
    logic [33:0]       p;
    logic [16:0]       m0;
    logic [16:0]       mb;
    vs = scrgb_pkg::to_s(v);

    // red: falling floor plus a steep rise above one half (10/3 slope)
    p  = 34'(v) * 34'(scrgb_pkg::WAVE_SLOPE) + 34'(scrgb_pkg::Q_HALF);
    t0 = scrgb_pkg::to_s(scrgb_pkg::WAVE_BASE) -
         scrgb_pkg::s_t'({{(scrgb_pkg::SW-17){1'b0}}, p[32:16]});
    if (t0 < 0) begin
      t0 = '0;
    end
    n0 = vs - scrgb_pkg::to_s(scrgb_pkg::Q_HALF);
    m0 = n0[16:0] + 17'd1;
    if (n0 <= 0) begin
      up = '0;
    end else begin
      up = (n0 <<< 1) + n0 +
           scrgb_pkg::s_t'({{(scrgb_pkg::SW-16){1'b0}}, scrgb_pkg::div3(m0)});
    end
    c.red = scrgb_pkg::sat_unit(t0 + up);

    // green: 4/3 slope capped at the knee, then unit slope
    tg = vs + scrgb_pkg::s_t'({{(scrgb_pkg::SW-16){1'b0}}, scrgb_pkg::div3(v + 17'd1)});
    if (tg > scrgb_pkg::to_s(scrgb_pkg::WAVE_KNEE)) begin
      tg = scrgb_pkg::to_s(scrgb_pkg::WAVE_KNEE);
    end
    add = (v > scrgb_pkg::WAVE_KNEE) ? vs - scrgb_pkg::to_s(scrgb_pkg::WAVE_KNEE) : '0;
    c.green = scrgb_pkg::sat_unit(tg + add);

    // blue: capped ramp minus a 10/9 notch around the dip point
    tb = vs + scrgb_pkg::to_s(scrgb_pkg::WAVE_KNEE);
    if (tb > scrgb_pkg::to_s(scrgb_pkg::Q_ONE)) begin
      tb = scrgb_pkg::to_s(scrgb_pkg::Q_ONE);
    end
    nb  = scrgb_pkg::abs_s(vs - scrgb_pkg::to_s(scrgb_pkg::WAVE_DIP));
    mb  = nb[16:0] + 17'd4;
    sub = nb + scrgb_pkg::s_t'({{(scrgb_pkg::SW-14){1'b0}}, scrgb_pkg::div9(mb)});
    c.blue = scrgb_pkg::sat_unit(tb - sub);
    return c;
  endfunction

  scrgb_pkg::q_t x_wheel;

  // fraction of 8x: low 13 bits moved up by three
  assign x_wheel = {1'b0, x[12:0], 3'b000};

  always_comb begin
    unique case (sel)
      scrgb_pkg::MAP_JET:    rgb = scrgb_pkg::jet(x);
      scrgb_pkg::MAP_HOT:    rgb = scrgb_pkg::hot(x);
      scrgb_pkg::MAP_GRAY:   rgb = '{red: x, green: x, blue: x};
      scrgb_pkg::MAP_HSV:    rgb = hsv(x);
      scrgb_pkg::MAP_BONE:   rgb = bone(x);
      scrgb_pkg::MAP_COPPER: rgb = copper(x);
      scrgb_pkg::MAP_WHEEL:  rgb = scrgb_pkg::jet(x_wheel);
      scrgb_pkg::MAP_WAVE:   rgb = wave(x);
      default:               rgb = scrgb_pkg::jet(x);
    endcase
  end

endmodule

@@ sv/scrgb_top_dummy_placeholder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrgb_quant - output scaling stage logic
// Scales the three Q16 channels to the output pixel width, rounding half up.
// ----------------------------------------------------------------------------
module scrgb_quant (
  input  scrgb_pkg::rgb_q_t rgb,
  output scrgb_pkg::pix_t   red,
  output scrgb_pkg::pix_t   green,
  output scrgb_pkg::pix_t   blue
);

  assign red   = scrgb_pkg::quant(rgb.red);
  assign green = scrgb_pkg::quant(rgb.green);
  assign blue  = scrgb_pkg::quant(rgb.blue);

endmodule
